FILE: rtl/lltm_pkg.sv
// Shared types and constants for the LCD line timing and mode unit.
// No dependencies; imported by every module of the block.
package lltm_pkg;

  // Line timing
  localparam logic [9:0] LINE_DOTS   = 10'd456;  // dots per scanline
  localparam logic [7:0] LAST_LINE   = 8'd153;   // last line before wrap
  localparam logic [7:0] VBLANK_LINE = 8'd144;   // first invisible line
  localparam logic [8:0] OAM_END     = 9'd80;    // end of OAM search
  localparam logic [8:0] XFER_END    = 9'd252;   // end of pixel transfer

  // LCD modes
  localparam logic [1:0] MODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_OAM    = 2'd2;
  localparam logic [1:0] MODE_XFER   = 2'd3;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_LCD_ENABLE    = 3'd0;
  localparam logic [2:0] REG_LINE_COMPARE  = 3'd1;
  localparam logic [2:0] REG_HBLANK_IRQ_EN = 3'd2;
  localparam logic [2:0] REG_VBLANK_IRQ_EN = 3'd3;
  localparam logic [2:0] REG_OAM_IRQ_EN    = 3'd4;
  localparam logic [2:0] REG_COINC_IRQ_EN  = 3'd5;

  typedef struct packed {
    logic       lcd_enable;
    logic [7:0] line_compare;
    logic       hblank_irq_en;
    logic       vblank_status_irq_en;
    logic       oam_irq_en;
    logic       coincidence_irq_en;
  } cfg_t;

  typedef struct packed {
    logic       clear_screen;
    logic [7:0] render_line;
    logic       render_valid;
    logic       status_irq;
    logic       vblank_irq;
    logic       coincidence;
    logic [1:0] lcd_mode;
    logic [7:0] line_number;
  } res_t;

endpackage

FILE: rtl/lltm_cfg.sv
// APB-style configuration registers of the LCD line timing unit.
// Depends on lltm_pkg (cfg_t, register indexes).
module lltm_cfg
  import lltm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lcd_enable           <= 1'b1;
      cfg.line_compare         <= 8'd0;
      cfg.hblank_irq_en        <= 1'b0;
      cfg.vblank_status_irq_en <= 1'b0;
      cfg.oam_irq_en           <= 1'b0;
      cfg.coincidence_irq_en   <= 1'b0;
    end else if (wr_en) begin
      case (idx)
        REG_LCD_ENABLE:    cfg.lcd_enable           <= pwdata[0];
        REG_LINE_COMPARE:  cfg.line_compare         <= pwdata[7:0];
        REG_HBLANK_IRQ_EN: cfg.hblank_irq_en        <= pwdata[0];
        REG_VBLANK_IRQ_EN: cfg.vblank_status_irq_en <= pwdata[0];
        REG_OAM_IRQ_EN:    cfg.oam_irq_en           <= pwdata[0];
        REG_COINC_IRQ_EN:  cfg.coincidence_irq_en   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_LCD_ENABLE:    prdata = {31'd0, cfg.lcd_enable};
      REG_LINE_COMPARE:  prdata = {24'd0, cfg.line_compare};
      REG_HBLANK_IRQ_EN: prdata = {31'd0, cfg.hblank_irq_en};
      REG_VBLANK_IRQ_EN: prdata = {31'd0, cfg.vblank_status_irq_en};
      REG_OAM_IRQ_EN:    prdata = {31'd0, cfg.oam_irq_en};
      REG_COINC_IRQ_EN:  prdata = {31'd0, cfg.coincidence_irq_en};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

FILE: rtl/lltm_step.sv
// Timing state (dots, line, mode, coincidence) and its per-request update.
// Depends on lltm_pkg (cfg_t, res_t, timing constants).
module lltm_step
  import lltm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       step_en,
  input  logic [7:0] cycles,
  output res_t       res
);

  logic [8:0] dot_counter, dot_counter_next;
  logic [7:0] line_counter, line_counter_next;
  logic [1:0] mode_reg, mode_reg_next;
  logic       coincidence_flag, coincidence_flag_next;

  logic [9:0] sum;
  logic       wrap;
  logic [7:0] line_inc;
  logic [1:0] mode;
  logic       coinc_irq;
  logic       mode_irq;

  always_comb begin
    sum      = {1'b0, dot_counter} + {2'b00, cycles};
    wrap     = (sum >= LINE_DOTS);
    line_inc = line_counter + 8'd1;

    dot_counter_next      = dot_counter;
    line_counter_next     = line_counter;
    mode_reg_next         = mode_reg;
    coincidence_flag_next = coincidence_flag;
    mode      = MODE_HBLANK;
    coinc_irq = 1'b0;
    mode_irq  = 1'b0;
    res       = '0;

    if (!cfg.lcd_enable) begin
      dot_counter_next  = 9'd0;
      line_counter_next = 8'd0;
      mode_reg_next     = MODE_HBLANK;
      res.clear_screen  = 1'b1;
    end else begin
      if (wrap) begin
        dot_counter_next = 9'(sum - LINE_DOTS);
        if (line_counter < VBLANK_LINE) begin
          res.render_valid = 1'b1;
          res.render_line  = line_counter;
        end
        if (line_inc == VBLANK_LINE) begin
          res.vblank_irq    = 1'b1;
          line_counter_next = line_inc;
        end else if (line_inc > LAST_LINE) begin
          line_counter_next = 8'd0;
        end else begin
          line_counter_next = line_inc;
        end
        coincidence_flag_next = (line_counter_next == cfg.line_compare);
        coinc_irq = coincidence_flag_next && cfg.coincidence_irq_en;
      end else begin
        dot_counter_next = sum[8:0];
      end

      if (line_counter_next >= VBLANK_LINE)  mode = MODE_VBLANK;
      else if (dot_counter_next < OAM_END)   mode = MODE_OAM;
      else if (dot_counter_next < XFER_END)  mode = MODE_XFER;
      else                                   mode = MODE_HBLANK;

      if (mode != mode_reg) begin
        mode_reg_next = mode;
        case (mode)
          MODE_HBLANK: mode_irq = cfg.hblank_irq_en;
          MODE_VBLANK: mode_irq = cfg.vblank_status_irq_en;
          MODE_OAM:    mode_irq = cfg.oam_irq_en;
          default:     mode_irq = 1'b0;
        endcase
      end
      res.status_irq = coinc_irq || mode_irq;
    end

    res.line_number = line_counter_next;
    res.lcd_mode    = mode_reg_next;
    res.coincidence = coincidence_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_counter      <= 9'd0;
      line_counter     <= 8'd0;
      mode_reg         <= MODE_HBLANK;
      coincidence_flag <= 1'b0;
    end else if (step_en) begin
      dot_counter      <= dot_counter_next;
      line_counter     <= line_counter_next;
      mode_reg         <= mode_reg_next;
      coincidence_flag <= coincidence_flag_next;
    end
  end

  // Dot counter never holds a full line
  a_dots_in_line: assert property (@(posedge clk) disable iff (rst)
    {1'b0, dot_counter} < LINE_DOTS)
    else $error("dot counter reached a full line");

  // Line counter stays within the frame
  a_line_in_frame: assert property (@(posedge clk) disable iff (rst)
    line_counter <= LAST_LINE)
    else $error("line counter past last line");

  // Vblank mode exactly on invisible lines while enabled and stepped
  a_vblank_mode: assert property (@(posedge clk) disable iff (rst)
    step_en && cfg.lcd_enable |=>
      ((line_counter >= VBLANK_LINE) == (mode_reg == MODE_VBLANK)))
    else $error("mode disagrees with line");

  // Render request only for a visible line
  a_render_visible: assert property (@(posedge clk) disable iff (rst)
    res.render_valid |-> (res.render_line < VBLANK_LINE) && !res.clear_screen)
    else $error("render request for invisible line");

endmodule

FILE: rtl/lcd_line_timing_mode_unit_top.sv
// Top level of the LCD line timing and mode unit: stream pipeline registers.
// Depends on lltm_pkg, lltm_cfg and lltm_step.
//
// Usage:
//   Each request on the slave stream carries a count of elapsed cycles.
//   The unit advances its dot/line counters, derives the LCD mode and
//   returns one result per request on the master stream: current line,
//   mode, coincidence flag, vblank and status interrupt pulses, a render
//   request for a finished visible line, and a screen clear when the
//   display is off. The user writes registers over the APB-style port only
//   while the unit is idle; the unit itself does not enforce this.
//
// Timing:
//   Accepted request -> input register -> step logic -> result register.
//   A request waits in the input register until the result register is free;
//   the stepped result is then registered and m_tvalid rises. Throughput is
//   one request per cycle while m_tready is high; the single add-and-compare
//   step between the input and result registers sets that figure.
//
// Reset (rst, synchronous): counters, mode and flags clear, lcd_enable = 1,
//   all other registers 0, both pipeline stages empty.
// Stall: while m_tready is low the result holds; one more request is
//   taken into the input register, then s_tready drops until the result
//   is taken.
module lcd_line_timing_mode_unit_top
  import lltm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // slave stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] elapsed_cycles
  // master stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] line_number, [9:8] lcd_mode, [10] coincidence, [11] vblank_irq,
  // [12] status_irq, [13] render_valid, [21:14] render_line,
  // [22] clear_screen, [23] zero
  output logic [23:0] m_tdata,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t       cfg;
  res_t       res;
  res_t       res_q;

  logic       s1_valid;
  logic [7:0] s1_cycles;
  logic       s_accept;
  logic       advance;

  // Step when the input stage holds a request and the result slot is free
  assign advance  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || advance;
  assign s_accept = s_tvalid && s_tready;

  lltm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lltm_step u_step (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .step_en (advance),
    .cycles  (s1_cycles),
    .res     (res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_cycles <= s_tdata;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign m_tdata = {1'b0, res_q};

  // A held request is not dropped while the result slot is busy
  a_hold_request: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_cycles))
    else $error("input stage lost a request");

  // A pending result is not overwritten before it is taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !advance)
    else $error("result overwritten while stalled");

  // A step always produces a result next cycle
  a_step_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("step without result");

endmodule
